// ===== rtl/ffpa_pkg.sv =====
// ffpa_pkg: shared types, field widths, status codes and defaults for the
// first-fit pool allocator; used by the channel interfaces and the top level
`default_nettype none
package ffpa_pkg;
    localparam int SIZE_W   = 21;
    localparam int ADDR_W   = 20;
    localparam int STATUS_W = 2;
    localparam int THR_W    = 21;

    localparam int POOL_BYTES_DEF   = 1048576;
    localparam int MAX_SEG_DEF      = 64;
    localparam int HEADER_BYTES_DEF = 32;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(4096);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_REL = 2'd2;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] payload;
        logic              used;
    } t_seg;
endpackage
`default_nettype wire

// ===== rtl/ffpa_if.sv =====
// ffpa channel interfaces: request, response and configuration write
// channels with valid/ready handshake; depend on ffpa_pkg
`default_nettype none
interface ffpa_req_if import ffpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] release_address;
    modport source (output valid, req_type, alloc_size, release_address, input ready);
    modport sink   (input valid, req_type, alloc_size, release_address, output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   grant_address;
    logic                split_skipped;
    modport source (output valid, status, grant_address, split_skipped, input ready);
    modport sink   (input valid, status, grant_address, split_skipped, output ready);
endinterface

interface ffpa_cfg_if import ffpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/first_fit_pool_allocator.sv =====
// first_fit_pool_allocator: segment table in one synchronous memory, walked
// by a read-modify-write sequencer; depends on ffpa_pkg and ffpa_if
//
// Usage:
// - i_req carries one allocate or release item; o_rsp returns exactly one
//   result item per request, in order; i_cfg writes split_threshold and is
//   always ready (write only while the block is idle).
// - The segment table (start, payload, used) lives in a one-port-read,
//   one-port-write memory with a registered read port.
// - The first-fit or release lookup reads one entry per cycle; an
//   allocate with a split then shifts the entries above it up, one read
//   and one write per moved entry; a release first reads both neighbors,
//   then, after merges, shifts the entries above down the same way.
// - Reset: the table holds one free segment covering the whole pool and
//   split_threshold is 4096. No clearing pass: only entry 0 has a reset
//   value, the others are written before they are read.
// - o_rsp is a registered output; a new request is accepted while a result
//   waits; if the receiver stalls, the next finished result holds the
//   sequencer until the output register frees.
`default_nettype none
module first_fit_pool_allocator import ffpa_pkg::*; #(
    parameter int POOL_BYTES   = POOL_BYTES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEG_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    ffpa_req_if.sink   i_req,
    ffpa_rsp_if.source o_rsp,
    ffpa_cfg_if.sink   i_cfg
);
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [21:0] HDR22 = 22'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HDR20 = ADDR_W'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
    localparam t_seg SEG0_RESET = '{start: '0,
                                   payload: SIZE_W'(POOL_BYTES - HEADER_BYTES),
                                   used: 1'b0};

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SRCH    = 4'd1;
    localparam logic [3:0] S_ALC     = 4'd2;
    localparam logic [3:0] S_SHUP_RD = 4'd3;
    localparam logic [3:0] S_SHUP_WR = 4'd4;
    localparam logic [3:0] S_RLS_P   = 4'd5;
    localparam logic [3:0] S_RLS_S   = 4'd6;
    localparam logic [3:0] S_RLS_D   = 4'd7;
    localparam logic [3:0] S_SHDN_RD = 4'd8;
    localparam logic [3:0] S_SHDN_WR = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    // segment table
    t_seg r_mem [MAX_SEGMENTS];
    t_seg r_rdata;
    logic r_rd_ovr;
    logic r_init0;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [THR_W-1:0]  r_thr;
    logic              r_type, n_type;
    logic [21:0]       r_need, n_need;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CW-1:0]     r_ra, n_ra;
    logic              r_pv, n_pv;
    logic [IW-1:0]     r_pi, n_pi;
    t_seg              r_f, n_f;
    logic [IW-1:0]     r_fi, n_fi;
    t_seg              r_p, n_p;
    logic [CW-1:0]     r_k, n_k;
    logic [1:0]        r_d, n_d;
    logic [21:0]       r_left, n_left;
    logic [ADDR_W-1:0] r_grant, n_grant;
    logic [STATUS_W-1:0] r_st, n_st;
    logic              r_sk, n_sk;
    logic              r_ov, n_ov;
    logic [STATUS_W-1:0] r_ost, n_ost;
    logic [ADDR_W-1:0] r_ogr, n_ogr;
    logic              r_osk, n_osk;

    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wa;
    t_seg          wd;
    t_seg          e;
    logic          req_acc;
    logic          hit;
    logic [21:0]   left;
    logic          want;
    logic          pm, sm;
    logic [21:0]   sum;
    logic [CW:0]   kd;

    assign e       = r_rd_ovr ? SEG0_RESET : r_rdata;
    assign req_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_ov;
    assign o_rsp.status = r_ost;
    assign o_rsp.grant_address = r_ogr;
    assign o_rsp.split_skipped = r_osk;

    // memory read and write ports
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    // entry 0 reads as its reset value until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init0  <= 1'b0;
            r_rd_ovr <= 1'b0;
        end else begin
            r_rd_ovr <= (rd_addr == '0) && !r_init0;
            if (we && wa == '0) begin
                r_init0 <= 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_count = r_count; n_type = r_type; n_need = r_need;
        n_addr = r_addr; n_ra = r_ra; n_pv = r_pv; n_pi = r_pi; n_f = r_f; n_fi = r_fi;
        n_p = r_p; n_k = r_k; n_d = r_d; n_left = r_left; n_grant = r_grant;
        n_st = r_st; n_sk = r_sk; n_ov = r_ov; n_ost = r_ost; n_ogr = r_ogr; n_osk = r_osk;
        rd_addr = '0; we = 1'b0; wa = '0; wd = e;
        hit = 1'b0; left = '0; want = 1'b0; pm = 1'b0; sm = 1'b0; sum = '0; kd = '0;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_type  = i_req.req_type;
                    n_need  = {1'b0, i_req.alloc_size} + HDR22;
                    n_addr  = i_req.release_address;
                    n_ra    = '0;
                    n_pv    = 1'b0;
                    n_st    = ST_OK;
                    n_sk    = 1'b0;
                    n_grant = '0;
                    n_state = S_SRCH;
                end
            end
            // one entry read per cycle, evaluated in the next cycle
            S_SRCH: begin
                rd_addr = r_ra[IW-1:0];
                if (r_ra < r_count) begin
                    n_ra = r_ra + 1'b1;
                    n_pv = 1'b1;
                    n_pi = r_ra[IW-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (r_type == REQ_ALLOC) begin
                        hit = !e.used && ({1'b0, e.payload} >= r_need);
                    end else begin
                        hit = e.used && ({1'b0, e.start} + {1'b0, HDR20} == {1'b0, r_addr});
                    end
                    if (hit) begin
                        n_f = e;
                        n_fi = r_pi;
                        n_state = (r_type == REQ_ALLOC) ? S_ALC : S_RLS_P;
                    end else if (CW'(r_pi) == r_count - 1'b1) begin
                        n_st = (r_type == REQ_ALLOC) ? ST_NO_FIT : ST_BAD_REL;
                        n_state = S_DONE;
                    end
                end
            end
            // mark used, decide on a split
            S_ALC: begin
                left = {1'b0, r_f.payload} - r_need;
                want = (left > {1'b0, r_thr}) && (left > HDR22);
                we = 1'b1;
                wa = r_fi;
                wd = r_f;
                wd.used = 1'b1;
                n_grant = r_f.start + HDR20;
                if (want && r_count < MAXC) begin
                    wd.payload = r_need[SIZE_W-1:0];
                    n_left = left;
                    n_k = r_count;
                    n_state = S_SHUP_RD;
                end else begin
                    n_sk = want;
                    n_state = S_DONE;
                end
            end
            // open a hole at fi+1
            S_SHUP_RD: begin
                if ({1'b0, r_k} > {1'b0, CW'(r_fi)} + 1'b1) begin
                    rd_addr = IW'(r_k - 1'b1);
                    n_state = S_SHUP_WR;
                end else begin
                    we = 1'b1;
                    wa = IW'(r_fi + 1'b1);
                    wd.start = r_grant + r_need[ADDR_W-1:0];
                    wd.payload = SIZE_W'(r_left - HDR22);
                    wd.used = 1'b0;
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SHUP_WR: begin
                we = 1'b1;
                wa = r_k[IW-1:0];
                wd = e;
                n_k = r_k - 1'b1;
                n_state = S_SHUP_RD;
            end
            // fetch neighbors
            S_RLS_P: begin
                rd_addr = r_fi - 1'b1;
                n_state = S_RLS_S;
            end
            S_RLS_S: begin
                n_p = e;
                rd_addr = r_fi + 1'b1;
                n_state = S_RLS_D;
            end
            // merge and write the surviving entry
            S_RLS_D: begin
                pm = (r_fi != '0) && !r_p.used &&
                     ({2'b0, r_p.start} + HDR22 + {1'b0, r_p.payload} == {2'b0, r_f.start});
                sm = ({1'b0, CW'(r_fi)} + 1'b1 < {1'b0, r_count}) && !e.used &&
                     ({2'b0, r_f.start} + HDR22 + {1'b0, r_f.payload} == {2'b0, e.start});
                sum = {1'b0, r_f.payload}
                    + (pm ? {1'b0, r_p.payload} + HDR22 : 22'd0)
                    + (sm ? {1'b0, e.payload} + HDR22 : 22'd0);
                we = 1'b1;
                wa = pm ? r_fi - 1'b1 : r_fi;
                wd.start = pm ? r_p.start : r_f.start;
                wd.payload = sum[SIZE_W-1:0];
                wd.used = 1'b0;
                n_d = {1'b0, pm} + {1'b0, sm};
                n_k = pm ? CW'(r_fi) : CW'(r_fi) + 1'b1;
                n_state = S_SHDN_RD;
            end
            // close the gap left by merged entries
            S_SHDN_RD: begin
                kd = {1'b0, r_k} + {{(CW - 1){1'b0}}, r_d};
                if (kd < {1'b0, r_count}) begin
                    rd_addr = kd[IW-1:0];
                    n_state = S_SHDN_WR;
                end else begin
                    n_count = r_count - CW'(r_d);
                    n_state = S_DONE;
                end
            end
            S_SHDN_WR: begin
                we = 1'b1;
                wa = r_k[IW-1:0];
                wd = e;
                n_k = r_k + 1'b1;
                n_state = S_SHDN_RD;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov = 1'b1;
                    n_ost = r_st;
                    n_ogr = (r_st == ST_OK && r_type == REQ_ALLOC) ? r_grant : '0;
                    n_osk = r_sk;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_thr   <= THR_RESET;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_pv    <= n_pv;
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.data;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_type <= n_type; r_need <= n_need; r_addr <= n_addr; r_ra <= n_ra;
        r_pi <= n_pi; r_f <= n_f; r_fi <= n_fi; r_p <= n_p; r_k <= n_k; r_d <= n_d;
        r_left <= n_left; r_grant <= n_grant; r_st <= n_st; r_sk <= n_sk;
        r_ost <= n_ost; r_ogr <= n_ogr; r_osk <= n_osk;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= MAXC)
        else $error("segment count out of range");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SRCH) |=> $stable(r_count))
        else $error("segment count changed during lookup");
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.grant_address == '0 &&
        !o_rsp.split_skipped))
        else $error("failed item carries grant or skip flag");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SRCH || r_state == S_DONE) |-> !we)
        else $error("table written outside an update step");
`endif
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for first_fit_pool_allocator
// drives allocate/release items with random idling, predicts results with a
// segment table model; depends on ffpa_pkg, ffpa_if and the rtl top level
`default_nettype none
module tb_top;
    import ffpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL  = POOL_BYTES_DEF;
    localparam int NSEG  = MAX_SEG_DEF;
    localparam int HDR   = HEADER_BYTES_DEF;
    localparam int WDOG  = 20000;
    localparam int NRAND = 1600;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   grant;
        logic                skipped;
    } t_alloc_rsp;

    typedef struct {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                fixed;
        t_alloc_rsp        rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ffpa_req_if req_ch ();
    ffpa_rsp_if rsp_ch ();
    ffpa_cfg_if cfg_ch ();

    first_fit_pool_allocator u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: pool segment table and threshold
    int unsigned pool_start [NSEG];
    int unsigned pool_pay   [NSEG];
    bit          pool_used  [NSEG];
    int unsigned pool_count;
    int unsigned pool_thr;

    t_alloc_rsp  pending_rsp [$];
    int unsigned used_addrs [$];
    int          fail_cnt = 0;
    int          idle_cnt = 0;
    int          send_idle = 0;
    int          recv_idle = 0;

    function automatic void pool_reset();
        for (int i = 0; i < NSEG; i++) begin
            pool_start[i] = 0;
            pool_pay[i] = 0;
            pool_used[i] = 0;
        end
        pool_pay[0] = POOL - HDR;
        pool_count = 1;
        pool_thr = 4096;
    endfunction

    // fold entry a+1 into entry a
    function automatic void pool_fold(int unsigned a);
        pool_pay[a] += pool_pay[a + 1] + HDR;
        for (int unsigned k = a + 1; k + 1 < pool_count; k++) begin
            pool_start[k] = pool_start[k + 1];
            pool_pay[k] = pool_pay[k + 1];
            pool_used[k] = pool_used[k + 1];
        end
        pool_count--;
    endfunction

    function automatic bit pool_adj(int unsigned a, int unsigned b);
        return pool_start[a] + HDR + pool_pay[a] == pool_start[b];
    endfunction

    function automatic t_alloc_rsp pool_apply(logic kind, logic [SIZE_W-1:0] size,
                                              logic [ADDR_W-1:0] addr);
        t_alloc_rsp  r;
        int unsigned need, found, left, g;
        r = '0;
        found = pool_count;
        if (kind == REQ_ALLOC) begin
            need = size + HDR;
            for (int unsigned i = 0; i < pool_count; i++)
                if (!pool_used[i] && pool_pay[i] >= need) begin
                    found = i;
                    break;
                end
            if (found >= pool_count) begin
                r.status = ST_NO_FIT;
            end else begin
                left = pool_pay[found] - need;
                pool_used[found] = 1;
                g = pool_start[found] + HDR;
                r.grant = ADDR_W'(g);
                if (left > pool_thr && left > HDR) begin
                    if (pool_count >= NSEG) begin
                        r.skipped = 1'b1;
                    end else begin
                        for (int unsigned k = pool_count; k > found + 1; k--) begin
                            pool_start[k] = pool_start[k - 1];
                            pool_pay[k] = pool_pay[k - 1];
                            pool_used[k] = pool_used[k - 1];
                        end
                        pool_pay[found] = need;
                        pool_start[found + 1] = g + need;
                        pool_pay[found + 1] = left - HDR;
                        pool_used[found + 1] = 0;
                        pool_count++;
                    end
                end
                used_addrs.push_back(g);
            end
        end else begin
            for (int unsigned i = 0; i < pool_count; i++)
                if (pool_used[i] && pool_start[i] + HDR == addr) begin
                    found = i;
                    break;
                end
            if (found >= pool_count) begin
                r.status = ST_BAD_REL;
            end else begin
                pool_used[found] = 0;
                if (found > 0 && !pool_used[found - 1] && pool_adj(found - 1, found)) begin
                    pool_fold(found - 1);
                    found--;
                end
                if (found + 1 < pool_count && !pool_used[found + 1]
                        && pool_adj(found, found + 1))
                    pool_fold(found);
                foreach (used_addrs[j])
                    if (used_addrs[j] == addr) begin
                        used_addrs.delete(j);
                        break;
                    end
            end
        end
        return r;
    endfunction

    // send one item and queue its expected result; valid drops only when idling
    task automatic send_item(logic kind, logic [SIZE_W-1:0] size,
                             logic [ADDR_W-1:0] addr, bit fixed, t_alloc_rsp fx);
        t_alloc_rsp p;
        if ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.alloc_size <= size;
        req_ch.release_address <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        p = pool_apply(kind, size, addr);
        if (fixed && p != fx) begin
            $error("directed row: predicted %h, table %h", p, fx);
            fail_cnt++;
        end
        pending_rsp.push_back(p);
    endtask

    task automatic drain();
        int n;
        n = 0;
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        while (n < 4 * NSEG) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic write_thr(int unsigned v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= THR_W'(v);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        pool_thr = v;
    endtask

    // random item: mostly allocs and releases of live blocks
    task automatic send_random();
        int unsigned sel, sz, ad;
        sel = $urandom_range(99);
        if (sel < 50) begin
            case ($urandom_range(9))
                0: sz = $urandom_range(1048576);
                1: sz = $urandom_range(65535);
                default: sz = $urandom_range(20000);
            endcase
            send_item(REQ_ALLOC, SIZE_W'(sz), ADDR_W'($urandom), 0, '0);
        end else if (sel < 90 && used_addrs.size() != 0) begin
            ad = used_addrs[$urandom_range(used_addrs.size() - 1)];
            send_item(REQ_RELEASE, SIZE_W'($urandom), ADDR_W'(ad), 0, '0);
        end else begin
            send_item(REQ_RELEASE, SIZE_W'($urandom), ADDR_W'($urandom), 0, '0);
        end
    endtask

    // receiver: random stall and compare against oldest expectation
    always @(posedge i_clk) begin
        t_alloc_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            idle_cnt <= 0;
            if (pending_rsp.size() == 0) begin
                $error("unexpected result item");
                fail_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, rsp_ch.status);
                    fail_cnt++;
                end
                if (rsp_ch.grant_address !== e.grant) begin
                    $error("grant_address exp %h got %h", e.grant, rsp_ch.grant_address);
                    fail_cnt++;
                end
                if (rsp_ch.split_skipped !== e.skipped) begin
                    $error("split_skipped exp %b got %b", e.skipped, rsp_ch.split_skipped);
                    fail_cnt++;
                end
            end
        end else if (req_ch.valid && req_ch.ready) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (idle_cnt >= WDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    t_row dir_rows [$];

    function automatic t_row mk(logic k, int unsigned s, int unsigned a, bit f,
                                logic [1:0] st, int unsigned g, bit sk);
        t_row r;
        r.kind = k;
        r.size = SIZE_W'(s);
        r.addr = ADDR_W'(a);
        r.fixed = f;
        r.rsp.status = st;
        r.rsp.grant = ADDR_W'(g);
        r.rsp.skipped = sk;
        return r;
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.alloc_size = '0;
        req_ch.release_address = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        pool_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: bad release, too-large, extremes, merges
        dir_rows.push_back(mk(REQ_RELEASE, 0, 32, 1, ST_BAD_REL, 0, 0));
        dir_rows.push_back(mk(REQ_ALLOC, 1048576, 0, 1, ST_NO_FIT, 0, 0));
        dir_rows.push_back(mk(REQ_ALLOC, 0, 0, 1, ST_OK, 32, 0));
        dir_rows.push_back(mk(REQ_ALLOC, 100, 0, 1, ST_OK, 96, 0));
        dir_rows.push_back(mk(REQ_ALLOC, 5000, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(REQ_RELEASE, 0, 96, 0, 0, 0, 0));
        dir_rows.push_back(mk(REQ_RELEASE, 0, 96, 1, ST_BAD_REL, 0, 0));
        dir_rows.push_back(mk(REQ_RELEASE, 0, 32, 0, 0, 0, 0));
        dir_rows.push_back(mk(REQ_ALLOC, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(REQ_RELEASE, 'h1FFFFF, 'hFFFFF, 1, ST_BAD_REL, 0, 0));
        dir_rows.push_back(mk(REQ_ALLOC, 1048576 - 64, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(REQ_ALLOC, 'h1FFFFF, 0, 1, ST_NO_FIT, 0, 0));
        dir_rows.push_back(mk(REQ_RELEASE, 0, 32, 0, 0, 0, 0));
        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].size, dir_rows[i].addr,
                      dir_rows[i].fixed, dir_rows[i].rsp);

        // random phases: threshold settings and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: write_thr(0);
                1: write_thr(1048576);
                2: write_thr(2097151);
                3: write_thr(64);
                4: write_thr(32);
                5: write_thr($urandom_range(8192));
                6: write_thr(4096);
                default: write_thr(256);
            endcase
            send_idle = (ph < 3) ? 23 : (ph < 6) ? 50 : 0;
            recv_idle = (ph < 3) ? 50 : (ph < 6) ? 23 : 0;
            for (int i = 0; i < NRAND / 8; i++)
                send_random();
        end
        // release everything to reach coalesce back to one segment
        while (used_addrs.size() != 0)
            send_item(REQ_RELEASE, '0, ADDR_W'(used_addrs[0]), 0, '0);
        drain();
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/ffpa_pkg.sv
rtl/ffpa_if.sv
rtl/first_fit_pool_allocator.sv
sim/tb_top.sv
